// ===== sv/crfd_pkg.sv =====
// ----------------------------------------------------------------------------
// crfd_pkg
// Shared types, codes and constants of the capture file rotation decision.
// ----------------------------------------------------------------------------
package crfd_pkg;

  localparam int unsigned OffsetW  = 40;
  localparam int unsigned LenW     = 16;
  localparam int unsigned HdrW     = 16;
  localparam int unsigned FieldW   = 8;   // widest time field, also modulus width
  localparam int unsigned DivSteps = FieldW;
  localparam int unsigned StepCntW = $clog2(DivSteps);
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [OffsetW-1:0] OffsetMax    = '1;
  localparam logic [OffsetW-1:0] SizeLimitRst = 40'd1073741824;
  localparam logic [HdrW-1:0]    HeaderRst    = 16'd24;
  localparam logic [7:0]         PeriodCntRst = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STORE_EN,
    REG_SIZE_EN,
    REG_SIZE_LIMIT,
    REG_TIME_EN,
    REG_PERIOD_UNIT,
    REG_PERIOD_COUNT,
    REG_HEADER_BYTES
  } reg_idx_e;

  typedef enum logic [2:0] {
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR,
    UNIT_DAY,
    UNIT_MONTH,
    UNIT_YEAR
  } unit_e;

  typedef enum logic [1:0] {
    CAUSE_NONE,
    CAUSE_SIZE,
    CAUSE_TIME
  } cause_e;

  // Early outcome of the period check, or defer to the aligned compare.
  typedef enum logic [1:0] {
    NP_NO,
    NP_YES,
    NP_CMP
  } np_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } wtime_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

// ===== sv/crfd_rem.sv =====
// ----------------------------------------------------------------------------
// crfd_rem
// Restoring remainder lane: one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module crfd_rem import crfd_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic              step_i,
  input  logic [FieldW-1:0] value_i,
  input  logic [FieldW-1:0] modulus_i,
  output logic [FieldW-1:0] rem_o
);

  logic [FieldW-1:0] value_q, value_d;
  logic [FieldW-1:0] rem_q, rem_d;
  logic [FieldW:0]   trial;
  logic [FieldW:0]   diff;

  assign trial = {rem_q, value_q[FieldW-1]};
  assign diff  = trial - {1'b0, modulus_i};

  always_comb begin
    value_d = value_q;
    rem_d   = rem_q;
    if (load_i) begin
      value_d = value_i;
      rem_d   = '0;
    end else if (step_i) begin
      value_d = {value_q[FieldW-2:0], 1'b0};
      // subtract when the trial remainder reaches the modulus
      rem_d   = diff[FieldW] ? trial[FieldW-1:0] : diff[FieldW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rem_q   <= rem_d;
  end

  assign rem_o = rem_q;

endmodule

// ===== sv/crfd_dp.sv =====
// ----------------------------------------------------------------------------
// crfd_dp
// Datapath: configuration registers, file state, period check and result.
// ----------------------------------------------------------------------------
module crfd_dp import crfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [OffsetW-1:0] cfg_wdata_i,
  input  logic [LenW-1:0]    pkt_len_i,
  input  wtime_t             now_i,
  output logic               rotated_o,
  output logic [1:0]         rotate_cause_o,
  output logic [OffsetW-1:0] write_offset_o
);

  // configuration
  logic               store_en_q, size_en_q, time_en_q;
  logic [OffsetW-1:0] size_limit_q;
  logic [2:0]         period_unit_q;
  logic [7:0]         period_cnt_q;
  logic [HdrW-1:0]    header_q;

  // file state
  logic [OffsetW-1:0] file_offset_q, file_offset_d;
  wtime_t             last_q, last_d;

  // captured item and prepared flags
  logic [LenW-1:0]    len_q;
  wtime_t             cur_q;
  np_e                np_kind_q, np_kind_d;
  logic               size_hit_q, size_hit_d;
  logic               later_q, later_d;
  logic [FieldW-1:0]  a_q, b_q, a_d, b_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  // result registers
  logic               rotated_q;
  cause_e             cause_q, cause_d;
  logic [OffsetW-1:0] woff_q, woff_d;

  logic [FieldW-1:0]  modulus;
  logic [FieldW-1:0]  rem_a, rem_b;
  logic               same_y, same_mo, same_d, same_h, same_mi;
  logic               up_y, up_mo, up_d, up_h, up_mi;
  logic [FieldW-1:0]  align_a, align_b;
  logic               new_period;
  logic [OffsetW-1:0] base;
  logic [OffsetW:0]   sum;
  logic [OffsetW:0]   size_sum;

  function automatic logic later_than(input wtime_t x, input wtime_t y);
    logic r;
    if (x.year != y.year) begin
      r = x.year > y.year;
    end else if (x.month != y.month) begin
      r = x.month > y.month;
    end else if (x.day != y.day) begin
      r = x.day > y.day;
    end else if (x.hour != y.hour) begin
      r = x.hour > y.hour;
    end else if (x.minute != y.minute) begin
      r = x.minute > y.minute;
    end else begin
      r = x.second > y.second;
    end
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_en_q    <= 1'b1;
      size_en_q     <= 1'b1;
      size_limit_q  <= SizeLimitRst;
      time_en_q     <= 1'b1;
      period_unit_q <= UNIT_DAY;
      period_cnt_q  <= PeriodCntRst;
      header_q      <= HeaderRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STORE_EN:     store_en_q    <= cfg_wdata_i[0];
        REG_SIZE_EN:      size_en_q     <= cfg_wdata_i[0];
        REG_SIZE_LIMIT:   size_limit_q  <= cfg_wdata_i;
        REG_TIME_EN:      time_en_q     <= cfg_wdata_i[0];
        REG_PERIOD_UNIT:  period_unit_q <= cfg_wdata_i[2:0];
        REG_PERIOD_COUNT: period_cnt_q  <= cfg_wdata_i[7:0];
        REG_HEADER_BYTES: header_q      <= cfg_wdata_i[HdrW-1:0];
        default: ;
      endcase
    end
  end

  // Period check preparation: early decision and the unit values to align
  always_comb begin
    same_y  = last_q.year == cur_q.year;
    same_mo = same_y  && (last_q.month  == cur_q.month);
    same_d  = same_mo && (last_q.day    == cur_q.day);
    same_h  = same_d  && (last_q.hour   == cur_q.hour);
    same_mi = same_h  && (last_q.minute == cur_q.minute);
    up_y    = last_q.year < cur_q.year;
    up_mo   = up_y  || (last_q.month  < cur_q.month);
    up_d    = up_mo || (last_q.day    < cur_q.day);
    up_h    = up_d  || (last_q.hour   < cur_q.hour);
    up_mi   = up_h  || (last_q.minute < cur_q.minute);

    np_kind_d = NP_CMP;
    a_d       = '0;
    b_d       = '0;
    case (period_unit_q)
      UNIT_SEC: begin
        if (same_mi && (last_q.second == cur_q.second)) np_kind_d = NP_NO;
        else if (up_mi) np_kind_d = NP_YES;
        a_d = FieldW'(last_q.second);
        b_d = FieldW'(cur_q.second);
      end
      UNIT_MIN: begin
        if (same_mi) np_kind_d = NP_NO;
        else if (up_h) np_kind_d = NP_YES;
        a_d = FieldW'(last_q.minute);
        b_d = FieldW'(cur_q.minute);
      end
      UNIT_HOUR: begin
        if (same_h) np_kind_d = NP_NO;
        else if (up_d) np_kind_d = NP_YES;
        a_d = FieldW'(last_q.hour);
        b_d = FieldW'(cur_q.hour);
      end
      UNIT_DAY: begin
        if (same_d) np_kind_d = NP_NO;
        else if (up_mo) np_kind_d = NP_YES;
        // day of month counts from one; day zero aligns like day one
        a_d = (last_q.day != '0) ? FieldW'(last_q.day - 5'd1) : '0;
        b_d = (cur_q.day  != '0) ? FieldW'(cur_q.day  - 5'd1) : '0;
      end
      UNIT_MONTH: begin
        if (same_mo) np_kind_d = NP_NO;
        else if (up_y) np_kind_d = NP_YES;
        a_d = FieldW'(last_q.month);
        b_d = FieldW'(cur_q.month);
      end
      UNIT_YEAR: begin
        a_d = last_q.year;
        b_d = cur_q.year;
      end
      default: np_kind_d = NP_NO;
    endcase

    size_sum   = {1'b0, file_offset_q} + (OffsetW+1)'(len_q);
    size_hit_d = size_sum > {1'b0, size_limit_q};
    later_d    = later_than(cur_q, last_q);
  end

  assign modulus = (period_cnt_q == '0) ? FieldW'(1) : period_cnt_q;

  crfd_rem u_rem_a (
    .clk_i     (clk_i),
    .load_i    (cmd_i.prep),
    .step_i    (cmd_i.step),
    .value_i   (a_d),
    .modulus_i (modulus),
    .rem_o     (rem_a)
  );

  crfd_rem u_rem_b (
    .clk_i     (clk_i),
    .load_i    (cmd_i.prep),
    .step_i    (cmd_i.step),
    .value_i   (b_d),
    .modulus_i (modulus),
    .rem_o     (rem_b)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.prep) cnt_d = '0;
    else if (cmd_i.step) cnt_d = cnt_q + StepCntW'(1);
  end

  assign status_o.div_last = cnt_q == StepCntW'(DivSteps - 1);

  // Decision and state update
  always_comb begin
    align_a    = a_q - rem_a;
    align_b    = b_q - rem_b;
    new_period = (np_kind_q == NP_YES) || ((np_kind_q == NP_CMP) && (align_b > align_a));

    cause_d = CAUSE_NONE;
    if (store_en_q) begin
      if (size_en_q && size_hit_q) cause_d = CAUSE_SIZE;
      else if (time_en_q && new_period) cause_d = CAUSE_TIME;
    end

    base = (cause_d != CAUSE_NONE) ? OffsetW'(header_q) : file_offset_q;
    sum  = {1'b0, base} + (OffsetW+1)'(len_q);

    file_offset_d = file_offset_q;
    woff_d        = '0;
    if (store_en_q) begin
      woff_d        = base;
      file_offset_d = sum[OffsetW] ? OffsetMax : sum[OffsetW-1:0];
    end

    last_d = later_q ? cur_q : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_offset_q <= '0;
      last_q        <= '0;
      cnt_q         <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.commit) begin
        file_offset_q <= file_offset_d;
        last_q        <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      len_q <= pkt_len_i;
      cur_q <= now_i;
    end
    if (cmd_i.prep) begin
      np_kind_q  <= np_kind_d;
      size_hit_q <= size_hit_d;
      later_q    <= later_d;
      a_q        <= a_d;
      b_q        <= b_d;
    end
    if (cmd_i.commit) begin
      rotated_q <= cause_d != CAUSE_NONE;
      cause_q   <= cause_d;
      woff_q    <= woff_d;
    end
  end

  assign rotated_o      = rotated_q;
  assign rotate_cause_o = cause_q;
  assign write_offset_o = woff_q;

endmodule

// ===== sv/crfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// crfd_ctrl
// Controller: sequences capture, preparation, remainder steps and commit.
// ----------------------------------------------------------------------------
module crfd_ctrl import crfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PREP;
      S_PREP: state_d = S_DIV;
      S_DIV:  if (status_i.div_last) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_PREP: cmd_o.prep = 1'b1;
      S_DIV:  cmd_o.step = 1'b1;
      S_DONE: cmd_o.commit = out_free;
      default: ;
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/capture_file_rotation_decision.sv =====
// Items are taken one at a time: the 8-step remainder unit aligns the
//   time periods down by the period count while the input stays stalled.
// The output register holds a result while the next item is taken and worked.
// Reset: asynchronous, active low; clears the file offset and the last write
//   time and loads the documented register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// capture_file_rotation_decision
// Decides per captured packet whether a new capture file starts (size limit
// or new local time period) and the offset at which the packet is written.
// ----------------------------------------------------------------------------
module capture_file_rotation_decision import crfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [OffsetW-1:0] cfg_wdata_i,

  // input item: one captured packet
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [LenW-1:0]    pkt_len_i,
  input  logic [7:0]         now_year_i,
  input  logic [3:0]         now_month_i,
  input  logic [4:0]         now_day_i,
  input  logic [4:0]         now_hour_i,
  input  logic [5:0]         now_minute_i,
  input  logic [5:0]         now_second_i,

  // result item
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               rotated_o,
  output logic [1:0]         rotate_cause_o,
  output logic [OffsetW-1:0] write_offset_o
);

  cmd_t    cmd;
  status_t status;
  wtime_t  now;

  // Pack the broken-down time fields into one word for the datapath.
  assign now.year   = now_year_i;
  assign now.month  = now_month_i;
  assign now.day    = now_day_i;
  assign now.hour   = now_hour_i;
  assign now.minute = now_minute_i;
  assign now.second = now_second_i;

  // Controller: one item at a time, capture -> prepare -> 8 steps -> commit.
  crfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: registers, file state, period alignment and the result register.
  crfd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pkt_len_i      (pkt_len_i),
    .now_i          (now),
    .rotated_o      (rotated_o),
    .rotate_cause_o (rotate_cause_o),
    .write_offset_o (write_offset_o)
  );

`ifndef SYNTHESIS
  // The rotated flag agrees with the cause code of the same result.
  a_rotated_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rotated_o == (rotate_cause_o != CAUSE_NONE)))
    else $error("rotated flag disagrees with rotate cause");

  // Only the three defined cause codes ever leave the block.
  a_cause_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rotate_cause_o == CAUSE_NONE || rotate_cause_o == CAUSE_SIZE ||
                     rotate_cause_o == CAUSE_TIME))
    else $error("undefined rotate cause code");

  // An accepted item keeps the input side stalled while it is worked.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again while an item is in flight");
`endif

endmodule
